// File: rtl/sobel_pkg.sv
package sobel_pkg;

  localparam int PIX_W        = 8;
  localparam int LINE_WIDTH_W = 11;
  localparam int THR_W        = 8;
  localparam int OUT_COL_W    = 10;
  localparam int OUT_ROW_W    = 12;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_PAD_W    = OUT_TDATA_W - PIX_W - OUT_COL_W - OUT_ROW_W;
  localparam int CFG_IDX_W    = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // one window column, index 0 is the top (oldest) row
  typedef logic [2:0][PIX_W-1:0] col_t;

  typedef struct packed {
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] lo;
  } thr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_HIGH_THR   = 2'd1,
    CFG_LOW_THR    = 2'd2
  } cfg_idx_e;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;
  localparam logic [THR_W-1:0]        HIGH_THR_RST   = 8'd200;
  localparam logic [THR_W-1:0]        LOW_THR_RST    = 8'd100;
  localparam logic [PIX_W-1:0]        PIX_MAX        = 8'd255;
  localparam int                      MIN_WIDTH      = 3;

endpackage

// File: rtl/sobel_line_buf.sv
module sobel_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  sobel_pkg::pix_t            wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output sobel_pkg::pix_t            rdata_o
);

  sobel_pkg::pix_t mem_q [DEPTH];
  sobel_pkg::pix_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on the same edge; the top level forwards around it
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sobel_col_cell.sv
module sobel_col_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  sobel_pkg::col_t     col_i,
  output sobel_pkg::col_t     col_o
);

  sobel_pkg::col_t col_q;
  sobel_pkg::col_t col_d;

  always_comb begin
    col_d = shift_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

// File: rtl/sobel_kernel.sv
module sobel_kernel (
  input  sobel_pkg::col_t  left_i,
  input  sobel_pkg::col_t  mid_i,
  input  sobel_pkg::col_t  right_i,
  input  sobel_pkg::thr_t  thr_i,
  output sobel_pkg::pix_t  edge_o
);

  logic [9:0]  gx_p, gx_n, gy_p, gy_n;
  logic [9:0]  ax, ay;
  logic [10:0] mag;
  logic [7:0]  sat, inv;

  always_comb begin
    // gx: right column minus left column, middle row weighted by two
    gx_p = 10'(right_i[0]) + 10'({right_i[1], 1'b0}) + 10'(right_i[2]);
    gx_n = 10'(left_i[0])  + 10'({left_i[1], 1'b0})  + 10'(left_i[2]);
    // gy: top row minus bottom row, middle column weighted by two
    gy_p = 10'(left_i[0]) + 10'({mid_i[0], 1'b0}) + 10'(right_i[0]);
    gy_n = 10'(left_i[2]) + 10'({mid_i[2], 1'b0}) + 10'(right_i[2]);
    ax   = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
    ay   = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);
    mag  = 11'(ax) + 11'(ay);
    sat  = (mag > 11'(sobel_pkg::PIX_MAX)) ? sobel_pkg::PIX_MAX : mag[7:0];
    inv  = sobel_pkg::PIX_MAX - sat;
    // high test wins when the thresholds cross
    if (inv > thr_i.hi) begin
      edge_o = sobel_pkg::PIX_MAX;
    end else if (inv < thr_i.lo) begin
      edge_o = '0;
    end else begin
      edge_o = inv;
    end
  end

endmodule

// File: rtl/sobel_edge_threshold_filter.sv
// Channel   | Dir | Fields (low bit first)
// s_axis    | in  | tdata: grey_pixel[7:0]; tuser: frame_start
// m_axis    | out | tdata: edge_level[7:0], out_column[17:8], out_row[29:18], zero[31:30]
// cfg       | in  | cfg_idx_i 0 line_width, 1 high_threshold, 2 low_threshold
//
// One pixel per clock, sustained while m_axis accepts results. A result word reaches m_axis
// through the line buffer read on the edge that accepts its pixel, the window column
// shift, then the kernel into the output register. The line buffers have one read and one
// write port each, which sets the one-pixel-per-cycle figure.
// Reset clears counters and pipeline valids, presets config; line buffers hold garbage
// until written. A stalled output word freezes the whole pipeline.
module sobel_edge_threshold_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [sobel_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // grey_pixel
  input  logic                                  s_axis_tuser,  // frame_start
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [sobel_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // edge_level, out_column, out_row
  input  logic                                  cfg_we_i,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sobel_pkg::LINE_WIDTH_W-1:0]    cfg_wdata_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > sobel_pkg::LINE_WIDTH_W) ? WW : sobel_pkg::LINE_WIDTH_W;
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [sobel_pkg::LINE_WIDTH_W-1:0] line_width_q;
  sobel_pkg::thr_t                    thr_q;
  logic [WW-1:0]                      eff_w;
  logic [EW-1:0]                      lw_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= sobel_pkg::LINE_WIDTH_RST;
      thr_q.hi     <= sobel_pkg::HIGH_THR_RST;
      thr_q.lo     <= sobel_pkg::LOW_THR_RST;
    end else if (cfg_we_i) begin
      case (sobel_pkg::cfg_idx_e'(cfg_idx_i))
        sobel_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_wdata_i;
        sobel_pkg::CFG_HIGH_THR:   thr_q.hi     <= cfg_wdata_i[sobel_pkg::THR_W-1:0];
        sobel_pkg::CFG_LOW_THR:    thr_q.lo     <= cfg_wdata_i[sobel_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lw_ext = EW'(line_width_q);
    if (lw_ext < EW'(sobel_pkg::MIN_WIDTH)) begin
      eff_w = WW'(sobel_pkg::MIN_WIDTH);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(lw_ext);
    end
  end

  // pipeline advance: output register free or being drained
  logic out_valid_q;
  logic adv;
  logic acc;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // stage 0: position counters
  logic [CW-1:0] col_q, col_d, c_cur;
  logic [RW-1:0] row_q, row_d, r_cur;
  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          emit;

  always_comb begin
    if (s_axis_tuser || (WW'(col_q) >= eff_w)) begin
      c_cur = '0;
    end else begin
      c_cur = col_q;
    end
    r_cur   = s_axis_tuser ? '0 : row_q;
    emit    = (c_cur >= CW'(2)) && (r_cur >= RW'(2));
    col_inc = WW'(c_cur) + WW'(1);
    row_inc = (RW + 1)'(r_cur) + (RW + 1)'(1);
    col_d   = CW'(col_inc);
    row_d   = r_cur;
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = (row_inc >= (RW + 1)'(MAX_HEIGHT)) ? '0 : RW'(row_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line buffer data arrives
  logic            s1_valid_q, s1_emit_q, s1_fwd_q;
  logic [CW-1:0]   s1_col_q;
  logic [RW-1:0]   s1_row_q;
  sobel_pkg::pix_t s1_pix_q, fwd_old_q, fwd_new_q;
  sobel_pkg::pix_t rd_old, rd_new, s1_old, s1_new;
  logic            s1_wr;

  assign s1_old = s1_fwd_q ? fwd_old_q : rd_old;
  assign s1_new = s1_fwd_q ? fwd_new_q : rd_new;
  assign s1_wr  = adv && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q  <= s_axis_tdata[sobel_pkg::PIX_W-1:0];
      s1_col_q  <= c_cur;
      s1_row_q  <= r_cur;
      s1_emit_q <= emit;
      // same column written on this edge: the buffer read returns stale data
      s1_fwd_q  <= s1_valid_q && (s1_col_q == c_cur);
      fwd_old_q <= s1_new;
      fwd_new_q <= s1_pix_q;
    end
  end

  sobel_line_buf #(.DEPTH(MAX_WIDTH)) u_buf_old (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (s1_new),
    .re_i    (acc),
    .raddr_i (c_cur),
    .rdata_o (rd_old)
  );

  sobel_line_buf #(.DEPTH(MAX_WIDTH)) u_buf_new (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (acc),
    .raddr_i (c_cur),
    .rdata_o (rd_new)
  );

  // window: chain of column cells, newest column enters on the right
  sobel_pkg::col_t chain [4];

  assign chain[3] = {s1_pix_q, s1_new, s1_old};

  for (genvar k = 0; k < 3; k++) begin : g_cell
    sobel_col_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (s1_wr),
      .col_i   (chain[k+1]),
      .col_o   (chain[k])
    );
  end

  // stage 2: window holds the neighborhood
  logic                           s2_valid_q;
  logic [sobel_pkg::OUT_COL_W-1:0] s2_col_q;
  logic [sobel_pkg::OUT_ROW_W-1:0] s2_row_q;
  sobel_pkg::pix_t                edge_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_col_q <= sobel_pkg::OUT_COL_W'(s1_col_q - CW'(2));
      s2_row_q <= sobel_pkg::OUT_ROW_W'(s1_row_q - RW'(2));
    end
  end

  sobel_kernel u_kernel (
    .left_i  (chain[0]),
    .mid_i   (chain[1]),
    .right_i (chain[2]),
    .thr_i   (thr_q),
    .edge_o  (edge_val)
  );

  // output register
  sobel_pkg::pix_t                 out_edge_q;
  logic [sobel_pkg::OUT_COL_W-1:0] out_col_q;
  logic [sobel_pkg::OUT_ROW_W-1:0] out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_edge_q <= edge_val;
      out_col_q  <= s2_col_q;
      out_row_q  <= s2_row_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{sobel_pkg::OUT_PAD_W{1'b0}}, out_row_q, out_col_q, out_edge_q};

  // a result only comes from an interior position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> (s1_col_q >= CW'(2)) && (s1_row_q >= RW'(2)))
    else $error("result flagged for a border position");

  // thresholded level is 0, 255 or inside the band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_edge_q == '0) || (out_edge_q == sobel_pkg::PIX_MAX) ||
                    ((out_edge_q >= thr_q.lo) && (out_edge_q <= thr_q.hi)))
    else $error("edge level outside threshold band");

  // consecutive pixels in a row advance the column by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s1_valid_q && !s_axis_tuser && !cfg_we_i &&
    ((WW'(s1_col_q) + WW'(1)) < eff_w) |=> (s1_col_q == $past(s1_col_q) + CW'(1)))
    else $error("column counter skipped");

  // back-to-back words on the same column must use the forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_valid_q && acc && (s1_col_q == c_cur) |=> s1_fwd_q)
    else $error("missed line buffer forward");

endmodule

// File: verif/tb_sobel_edge_threshold_filter.sv
`timescale 1ns / 1ps

module tb_sobel_edge_threshold_filter;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP = 40;

  typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_BINARY} texture_e;

  typedef struct packed {
    logic [sobel_pkg::OUT_ROW_W-1:0] row;
    logic [sobel_pkg::OUT_COL_W-1:0] col;
    sobel_pkg::pix_t                 level;
  } sobel_result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [sobel_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;   // grey_pixel
  logic                               s_axis_tuser = 1'b0; // frame_start
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [sobel_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;  // edge_level, out_column, out_row, zero pad
  logic                               cfg_we_i = 1'b0;
  logic [sobel_pkg::CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [sobel_pkg::LINE_WIDTH_W-1:0] cfg_wdata_i = '0;

  sobel_edge_threshold_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // filter state copy
  sobel_pkg::pix_t                    line_mem [2*MAX_W];
  bit                                 line_ok  [2*MAX_W];
  sobel_pkg::pix_t                    win      [9];
  int unsigned                        col_cnt;
  int unsigned                        row_cnt;
  logic [sobel_pkg::LINE_WIDTH_W-1:0] width_reg;
  logic [sobel_pkg::THR_W-1:0]        hi_reg;
  logic [sobel_pkg::THR_W-1:0]        lo_reg;
  sobel_result_t                      pending_results [$];

  bit          steady_flow = 1'b0;
  texture_e    tex_mode = TEX_NOISE;
  int          tex_base = 0;
  int          tex_amp = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_started = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles = 0;

  task automatic model_reset();
    foreach (line_ok[i]) line_ok[i] = 1'b0;
    foreach (win[i]) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = sobel_pkg::LINE_WIDTH_RST;
    hi_reg = sobel_pkg::HIGH_THR_RST;
    lo_reg = sobel_pkg::LOW_THR_RST;
  endtask

  function automatic int unsigned active_width();
    if (int'(width_reg) < sobel_pkg::MIN_WIDTH) return sobel_pkg::MIN_WIDTH;
    if (int'(width_reg) > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  // leading columns where both line stores hold written data
  function automatic int unsigned filled_cols();
    int unsigned n;
    n = 0;
    while (n < MAX_W && line_ok[n] && line_ok[MAX_W+n]) n++;
    return n;
  endfunction

  function automatic sobel_pkg::pix_t window_level();
    int gx, gy, mag, inv;
    gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
       - (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
    gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
       - (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    if (mag > 255) mag = 255;
    inv = 255 - mag;
    if (inv > int'(hi_reg)) return sobel_pkg::PIX_MAX;
    if (inv < int'(lo_reg)) return '0;
    return sobel_pkg::pix_t'(inv);
  endfunction

  task automatic model_pixel(input sobel_pkg::pix_t pix, input bit sof);
    int unsigned w, c;
    sobel_pkg::pix_t older, newer;
    sobel_result_t res;
    w = active_width();
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    c = col_cnt;
    older = line_mem[c];
    newer = line_mem[MAX_W+c];
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = older;
    win[5] = newer;
    win[8] = pix;
    line_mem[c] = newer;
    line_ok[c] = line_ok[MAX_W+c];
    line_mem[MAX_W+c] = pix;
    line_ok[MAX_W+c] = 1'b1;
    if (c >= 2 && row_cnt >= 2) begin
      res.level = window_level();
      res.col = sobel_pkg::OUT_COL_W'(c - 2);
      res.row = sobel_pkg::OUT_ROW_W'(row_cnt - 2);
      pending_results.push_back(res);
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= MAX_H) row_cnt = 0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_pixel(input sobel_pkg::pix_t pix, input bit sof);
    while (!steady_flow && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= sof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_pixel(pix, sof);
    pixels_sent++;
    if (sof) frames_started++;
    @(negedge clk_i);
  endtask

  task automatic set_texture(input texture_e mode);
    tex_mode = mode;
    tex_base = $urandom_range(0, 200);
    tex_amp = $urandom_range(4, 60);
  endtask

  task automatic send_run(input int unsigned n, input bit sof_first);
    int v;
    for (int unsigned i = 0; i < n; i++) begin
      case (tex_mode)
        TEX_NOISE:  v = $urandom_range(0, 255);
        TEX_SMOOTH: v = tex_base + $urandom_range(0, tex_amp);
        default:    v = $urandom_range(0, 1) ? 255 : 0;
      endcase
      if (v > 255) v = 255;
      send_pixel(sobel_pkg::pix_t'(v), sof_first && i == 0);
    end
  endtask

  // stop input, let every expected word drain, then let the pipe settle
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input sobel_pkg::cfg_idx_e idx,
                           input logic [sobel_pkg::LINE_WIDTH_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      sobel_pkg::CFG_LINE_WIDTH: width_reg = value;
      sobel_pkg::CFG_HIGH_THR:   hi_reg = value[sobel_pkg::THR_W-1:0];
      sobel_pkg::CFG_LOW_THR:    lo_reg = value[sobel_pkg::THR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_thresholds(input int hi, input int lo);
    // upper data bits are don't-care for the threshold registers
    write_reg(sobel_pkg::CFG_HIGH_THR, {3'($urandom_range(0, 7)), 8'(hi)});
    write_reg(sobel_pkg::CFG_LOW_THR, {3'($urandom_range(0, 7)), 8'(lo)});
  endtask

  task automatic test_directed();
    sobel_pkg::pix_t steps [12];
    steps = '{0, 0, 0, 0, 0, 0, 255, 255, 255, 255, 0, 255};
    // register value below the minimum acts as width 3; reset thresholds
    write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd1);
    // hard horizontal edges saturate the magnitude
    for (int i = 0; i < 12; i++) send_pixel(steps[i], i == 0);
    // stray pixel, then a frame start mid-row with a flat patch
    send_pixel(8'd77, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(8'd128, i == 0);
    drain_pipeline();
    // high below low: high test wins
    write_thresholds(20, 240);
    for (int i = 0; i < 9; i++) send_pixel(sobel_pkg::pix_t'(100 + 10 * (i % 3)), i == 0);
    drain_pipeline();
  endtask

  task automatic test_width_change();
    write_thresholds(180, 60);
    write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd8);
    set_texture(TEX_SMOOTH);
    send_run(8 * 4, 1'b1);
    drain_pipeline();
    // shrink mid-frame at a row boundary
    write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd5);
    send_run(5 * 3 + 4, 1'b0);
    drain_pipeline();
    // shrink below the current column
    write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd3);
    send_run(3 * 3, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned first, phase, kind, w, lim;
    int hi, lo;
    first = pixels_sent;
    phase = 0;
    while (pixels_sent - first < target) begin
      steady_flow = (phase >= 12 && phase < 18);
      set_texture(texture_e'($urandom_range(0, 2)));
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        if ($urandom_range(0, 99) < 40) begin
          drain_pipeline();
          case ($urandom_range(0, 4))
            0: begin hi = 255; lo = 0; end
            1: begin hi = 0; lo = 255; end
            2: begin hi = $urandom_range(0, 255); lo = hi; end
            default: begin
              lo = $urandom_range(0, 200);
              hi = $urandom_range(lo, 255);
            end
          endcase
          write_thresholds(hi, lo);
          w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
          write_reg(sobel_pkg::CFG_LINE_WIDTH, sobel_pkg::LINE_WIDTH_W'(w));
        end
        send_run(active_width() * $urandom_range(3, 7) + $urandom_range(0, 2), 1'b1);
      end else if (kind < 88) begin
        // width change without a frame start, only over columns already stored
        lim = filled_cols();
        if (lim > 24) lim = 24;
        if (lim >= 3) begin
          drain_pipeline();
          w = $urandom_range(3, lim);
          write_reg(sobel_pkg::CFG_LINE_WIDTH, sobel_pkg::LINE_WIDTH_W'(w));
          send_run(w * $urandom_range(1, 4) + $urandom_range(0, w - 1), 1'b0);
        end
      end else begin
        send_run($urandom_range(1, 20), 1'b0);
      end
      phase++;
    end
    steady_flow = 1'b0;
    drain_pipeline();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk_i) begin : result_check
    sobel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.level)
          flag_mismatch($sformatf("level %0d, want %0d (col %0d row %0d)",
                                  m_axis_tdata[7:0], want.level, want.col, want.row));
        if (m_axis_tdata[17:8] !== want.col)
          flag_mismatch($sformatf("column %0d, want %0d", m_axis_tdata[17:8], want.col));
        if (m_axis_tdata[29:18] !== want.row)
          flag_mismatch($sformatf("row %0d, want %0d", m_axis_tdata[29:18], want.row));
        if (m_axis_tdata[31:30] !== 2'b00)
          flag_mismatch($sformatf("pad bits %b", m_axis_tdata[31:30]));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    model_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_width_change();
    test_random(1450);
    $display("Sent %0d pixels in %0d frames, checked %0d edge words.",
             pixels_sent, frames_started, results_checked);
    $display("Covered crossed and equal thresholds, low width clamp, mid-frame width and frame restarts.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sobel_pkg.sv
rtl/sobel_line_buf.sv
rtl/sobel_col_cell.sv
rtl/sobel_kernel.sv
rtl/sobel_edge_threshold_filter.sv
verif/tb_sobel_edge_threshold_filter.sv
